/* rtl/svpp_pkg.sv */
// Shared types and constants for the servo status packet parser.
// No dependencies; every other file of the block imports this package.
package svpp_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_ARG    = 3'd1,
		KIND_GOOD   = 3'd2,
		KIND_BAD    = 3'd3,
		KIND_NORESP = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CLS_DATA    = 3'b001,
		CLS_SYNC    = 3'b010,
		CLS_TIMEOUT = 3'b100
	} cls_t;

	typedef enum logic [6:0] {
		PH_START1 = 7'b0000001,
		PH_START2 = 7'b0000010,
		PH_ID     = 7'b0000100,
		PH_LEN    = 7'b0001000,
		PH_ERR    = 7'b0010000,
		PH_ARGS   = 7'b0100000,
		PH_CKSUM  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       no_byte;
		logic       discard;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] arg_byte;
		logic [7:0] arg_index;
		logic [7:0] servo_id;
		logic [7:0] error_flags;
		logic [7:0] arg_count;
	} out_item_t;

	// Classified item passed from the front end to the parser.
	typedef struct packed {
		cls_t       cls;
		logic [7:0] rx_byte;
		logic       discard;
	} work_t;

endpackage

/* rtl/svpp_front.sv */
// Front end: classify each incoming item as data, sync byte or timeout.
// Depends on svpp_pkg.
module svpp_front import svpp_pkg::*; (
	input  in_item_t item,
	output work_t    work
);

	always_comb begin
		work.rx_byte = item.rx_byte;
		work.discard = item.discard;
		if (item.no_byte) begin
			work.cls = CLS_TIMEOUT;
		end else if (item.rx_byte == SYNC_BYTE) begin
			work.cls = CLS_SYNC;
		end else begin
			work.cls = CLS_DATA;
		end
	end

endmodule

/* rtl/svpp_queue.sv */
// Small FIFO of classified items between front end and parser.
// Depends on svpp_pkg.
module svpp_queue import svpp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  work_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output logic  rd_valid,
	output work_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	work_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == FULL_COUNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/svpp_back.sv */
// Back end: packet parser state machine and the result register.
// Depends on svpp_pkg.
module svpp_back import svpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      work_valid,
	input  work_t     work,
	output logic      work_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	phase_t     phase_q, phase_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] expected_q, expected_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] id_q, id_d;
	logic [7:0] err_q, err_d;
	logic [7:0] seen_inc;
	out_item_t  res_d;
	out_item_t  res_q;
	logic       res_valid_q;

	// Advance when an item waits and the result slot is free or being drained.
	assign work_take = work_valid && (!res_valid_q || pop);
	assign empty     = !res_valid_q;
	assign result    = res_q;
	assign seen_inc  = seen_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		seen_d     = seen_q;
		expected_d = expected_q;
		sum_d      = sum_q;
		id_d       = id_q;
		err_d      = err_q;
		res_d.kind      = KIND_NONE;
		res_d.arg_byte  = '0;
		res_d.arg_index = '0;
		if (work.cls == CLS_TIMEOUT) begin
			if (phase_q == PH_START1) begin
				res_d.kind = KIND_NORESP;
			end
		end else begin
			case (phase_q)
				PH_START2: begin
					if (work.cls == CLS_SYNC) begin
						phase_d = PH_ID;
					end
				end
				PH_ID: begin
					id_d    = work.rx_byte;
					sum_d   = work.rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					expected_d = work.rx_byte - LEN_OVERHEAD;
					sum_d      = sum_q + work.rx_byte;
					phase_d    = PH_ERR;
				end
				PH_ERR: begin
					err_d   = work.rx_byte;
					sum_d   = sum_q + work.rx_byte;
					seen_d  = '0;
					phase_d = (expected_q != '0) ? PH_ARGS : PH_CKSUM;
				end
				PH_ARGS: begin
					res_d.kind      = KIND_ARG;
					res_d.arg_byte  = work.rx_byte;
					res_d.arg_index = seen_q;
					sum_d           = sum_q + work.rx_byte;
					seen_d          = seen_inc;
					if (seen_inc == expected_q) begin
						phase_d = PH_CKSUM;
					end
				end
				PH_CKSUM: begin
					if (work.discard || (~sum_q == work.rx_byte)) begin
						res_d.kind = KIND_GOOD;
					end else begin
						res_d.kind = KIND_BAD;
					end
					phase_d = PH_START1;
				end
				default: begin
					// Hunting the first start byte; stray codes fall here too.
					phase_d = (work.cls == CLS_SYNC) ? PH_START2 : PH_START1;
				end
			endcase
		end
		res_d.servo_id    = id_d;
		res_d.error_flags = err_d;
		res_d.arg_count   = expected_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START1;
			seen_q      <= '0;
			expected_q  <= '0;
			sum_q       <= '0;
			id_q        <= '0;
			err_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (work_take) begin
				phase_q     <= phase_d;
				seen_q      <= seen_d;
				expected_q  <= expected_d;
				sum_q       <= sum_d;
				id_q        <= id_d;
				err_q       <= err_d;
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_take) begin
			res_q <= res_d;
		end
	end

endmodule

/* rtl/servo_status_packet_parser_core.sv */
// Top level of the servo status packet parser.
// Depends on svpp_pkg, svpp_front, svpp_queue and svpp_back.
//
// Usage:
//   Input channel (push/full, payload item): one received serial byte per
//   item, or a timeout event (no_byte set). discard selects echo mode, in
//   which the checksum byte always yields a "packet good" verdict.
//   Result channel (empty/pop, payload result): exactly one result per item,
//   in order: nothing, argument byte, packet good, checksum mismatch or no
//   response, together with the id, error byte and argument count held from
//   the latest header.
// Path: an item accepted into an idle block is written into the queue,
//   then taken by the parser into the result register, where it shows
//   and the earliest pop can take it.
// Throughput: one item per cycle while each result is popped as it shows.
// Stall: when pop is held low the result register holds, the parser stops,
//   and up to QUEUE_DEPTH items collect in the queue before full rises.
// Reset: arst_n clears the queue, the result valid flag and the parser; the
//   parser restarts hunting the first start byte with all held fields zero.
module servo_status_packet_parser_core import svpp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	work_t fe_work;
	work_t q_work;
	logic  q_valid;
	logic  q_take;
	logic  accept;

	// Take an item whenever the queue has room.
	assign accept = push && !full;

	svpp_front u_front (
		.item (item),
		.work (fe_work)
	);

	svpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (fe_work),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_work)
	);

	svpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (q_valid),
		.work       (q_work),
		.work_take  (q_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* rtl/svpp_checker.sv */
// Port-level checks for the servo status packet parser, bound to the top.
// Depends on svpp_pkg.
module svpp_checker import svpp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// Hold a waiting result until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_NONE || result.kind == KIND_ARG ||
			result.kind == KIND_GOOD || result.kind == KIND_BAD ||
			result.kind == KIND_NORESP))
		else $error("illegal result kind");

	a_arg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_ARG) |->
			(result.arg_byte == 8'd0 && result.arg_index == 8'd0))
		else $error("argument fields set on a non-argument result");

	a_arg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_ARG) |-> (result.arg_index < result.arg_count))
		else $error("argument index beyond argument count");

endmodule

bind servo_status_packet_parser_core svpp_checker u_svpp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
